[rtl/lae_pkg.sv]
// lae_pkg: shared types and constants of the linear adsr envelope generator
// no dependencies; imported by the envelope top level and its checker
`default_nettype none

package lae_pkg;

  // level format: unsigned fixed point, one integer bit
  localparam int LEVEL_FRAC_BITS = 23;
  localparam int LEVEL_W         = 24;
  localparam int MODE_W          = 2;
  localparam int PHASE_W         = 3;
  localparam int REG_W           = 32;
  localparam int ADDR_W          = 5;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(1) << LEVEL_FRAC_BITS;

  // register reset values
  localparam logic [MODE_W-1:0]  MODE_RST    = MODE_W'(0);
  localparam logic [LEVEL_W-1:0] ATTACK_RST  = LEVEL_W'(1748);
  localparam logic [LEVEL_W-1:0] DECAY_RST   = LEVEL_W'(1311);
  localparam logic [LEVEL_W-1:0] RELEASE_RST = LEVEL_W'(306);
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(5872026);

  typedef enum logic [PHASE_W-1:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADSR = 2'd0,
    MODE_ASR  = 2'd1,
    MODE_AR   = 2'd2
  } mode_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_GATE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_DECAY   = 3'd2,
    REG_RELEASE = 3'd3,
    REG_SUSTAIN = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

[rtl/linear_adsr_envelope.sv]
// linear_adsr_envelope: linear envelope generator, adsr / asr / ar shapes
// depends on lae_pkg for level format, phase, mode, command and register codes
`default_nettype none

// usage
//   request channel (req_valid / req_ready, cmd, gate): each request is either
//   a sample tick (cmd 0) or a gate change (cmd 1, new gate level on gate)
//   result channel (res_valid / res_ready, level, phase, busy_res): exactly
//   one result per request, the envelope state after that request
//   apb port: mode, attack_step, decay_step, release_step, sustain_level at
//   byte addresses 0, 4, 8, 12, 16; write only while no request is in flight
// timing
//   a request taken is captured in the input stage, then the state update
//   writes it into the level and phase registers, which show the result;
//   one request per cycle sustained while res_ready stays high, set by the
//   single add / compare pass that updates the level and phase registers
// stalls
//   the level and phase registers double as the result register; while a
//   result waits, one more request is held in the input stage, after which
//   req_ready drops until res_ready frees the result
// reset
//   synchronous, active high: level zero, phase off, gate released, registers
//   back to their defaults, both stages empty

module linear_adsr_envelope
  import lae_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [REG_W-1:0]     pwdata,
  output logic      [REG_W-1:0]     prdata,
  output logic                      pready,
  // requests
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic                 cmd,
  input  wire logic                 gate,
  // results
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic      [LEVEL_W-1:0]   level,
  output logic      [PHASE_W-1:0]   phase,
  output logic                      busy_res
);

  // configuration registers
  logic [MODE_W-1:0]  mode;
  logic [LEVEL_W-1:0] attack_step;
  logic [LEVEL_W-1:0] decay_step;
  logic [LEVEL_W-1:0] release_step;
  logic [LEVEL_W-1:0] sustain_level;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  // input stage
  logic s1_valid;
  logic s1_cmd;
  logic s1_gate;
  logic advance;

  // envelope state, also the result register
  logic [LEVEL_W-1:0] env_level;
  phase_t             env_phase;
  logic               gate_held;

  logic [LEVEL_W-1:0] env_level_next;
  phase_t             env_phase_next;
  logic               gate_held_next;

  // attack / decay arithmetic, one bit of headroom
  logic [LEVEL_W:0]   atk_sum;
  logic [LEVEL_W-1:0] atk_target;
  phase_t             atk_phase;
  logic [LEVEL_W:0]   dcy_floor;
  logic               is_ar;
  logic               adsr_or_asr;

  // ---------------------------------------------------------------------------
  // apb register file
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_RST;
      attack_step   <= ATTACK_RST;
      decay_step    <= DECAY_RST;
      release_step  <= RELEASE_RST;
      sustain_level <= SUSTAIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:    mode          <= pwdata[MODE_W-1:0];
        REG_ATTACK:  attack_step   <= pwdata[LEVEL_W-1:0];
        REG_DECAY:   decay_step    <= pwdata[LEVEL_W-1:0];
        REG_RELEASE: release_step  <= pwdata[LEVEL_W-1:0];
        REG_SUSTAIN: sustain_level <= pwdata[LEVEL_W-1:0];
        default:     ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:    prdata = REG_W'(mode);
      REG_ATTACK:  prdata = REG_W'(attack_step);
      REG_DECAY:   prdata = REG_W'(decay_step);
      REG_RELEASE: prdata = REG_W'(release_step);
      REG_SUSTAIN: prdata = REG_W'(sustain_level);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: input stage feeds the state update whenever the result slot
  // is empty or being emptied this cycle
  // ---------------------------------------------------------------------------
  assign advance   = s1_valid && (!res_valid || res_ready);
  assign req_ready = !s1_valid || !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_cmd  <= cmd;
      s1_gate <= gate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // envelope next state
  // ---------------------------------------------------------------------------
  assign is_ar       = (mode == MODE_AR);
  assign adsr_or_asr = (mode == MODE_ADSR) || (mode == MODE_ASR);

  // attack aims at full scale, or at the sustain level in asr
  assign atk_target = (mode == MODE_ASR) ? sustain_level : FULL_SCALE;
  assign atk_phase  = (mode == MODE_ASR) ? PH_SUSTAIN :
                      (is_ar ? PH_RELEASE : PH_DECAY);
  assign atk_sum    = {1'b0, env_level} + {1'b0, attack_step};
  assign dcy_floor  = {1'b0, sustain_level} + {1'b0, decay_step};

  always_comb begin
    env_level_next = env_level;
    env_phase_next = env_phase;
    gate_held_next = gate_held;

    if (s1_cmd == CMD_GATE) begin
      // rise restarts attack from current level; fall releases, not in ar
      if (s1_gate && !gate_held) begin
        env_phase_next = PH_ATTACK;
      end
      if (!s1_gate && gate_held) begin
        env_phase_next = PH_RELEASE;
      end
      gate_held_next = is_ar ? 1'b0 : s1_gate;
    end else begin
      case (env_phase)
        PH_ATTACK: begin
          if (adsr_or_asr || is_ar) begin
            if (atk_sum >= {1'b0, atk_target}) begin
              env_level_next = atk_target;
              env_phase_next = atk_phase;
            end else begin
              env_level_next = atk_sum[LEVEL_W-1:0];
            end
          end
        end
        PH_DECAY: begin
          // decay only exists in adsr; may lift a level that sits below sustain
          if (mode == MODE_ADSR) begin
            if ({1'b0, env_level} <= dcy_floor) begin
              env_level_next = sustain_level;
              env_phase_next = PH_SUSTAIN;
            end else begin
              env_level_next = env_level - decay_step;
            end
          end
        end
        PH_SUSTAIN: begin
          if (adsr_or_asr && !gate_held) begin
            env_phase_next = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          if (adsr_or_asr || is_ar) begin
            if (env_level <= release_step) begin
              env_level_next = '0;
              env_phase_next = PH_OFF;
              if (is_ar) begin
                gate_held_next = 1'b0;
              end
            end else begin
              env_level_next = env_level - release_step;
            end
          end
        end
        default: ;  // off, or an unused phase code: hold
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env_level <= '0;
      env_phase <= PH_OFF;
      gate_held <= 1'b0;
    end else if (advance) begin
      env_level <= env_level_next;
      env_phase <= env_phase_next;
      gate_held <= gate_held_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result fields straight from the state registers
  // ---------------------------------------------------------------------------
  assign level    = env_level;
  assign phase    = env_phase;
  assign busy_res = (env_phase != PH_OFF);

endmodule

`default_nettype wire

[rtl/lae_checker.sv]
// lae_checker: port-level assertions for the linear adsr envelope generator
// depends on lae_pkg; bound to linear_adsr_envelope at the end of this file
`default_nettype none

module lae_checker
  import lae_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic [LEVEL_W-1:0] level,
  input wire logic [PHASE_W-1:0] phase,
  input wire logic               busy_res
);

  // busy flag tracks the phase field
  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (busy_res == (phase != PH_OFF)))
    else $error("busy_res disagrees with phase");

  // the envelope only reaches off through zero level
  a_off_at_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (phase == PH_OFF)) |-> (level == '0))
    else $error("phase off with non-zero level");

  // a stalled result keeps its fields
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(level) && $stable(phase)))
    else $error("stalled result changed");

  // requests only stall behind a result that is itself stalled
  a_input_stall: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_ready) |-> (res_valid && !res_ready))
    else $error("request stalled with the result slot free");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !res_valid)
    else $error("result shown straight after reset");

endmodule

bind linear_adsr_envelope lae_checker u_lae_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .level     (level),
  .phase     (phase),
  .busy_res  (busy_res)
);

`default_nettype wire
